/* hw/rtl/sit_pkg.sv */
// Shared types, codes and constants for the sorted interval table.
`default_nettype none
package sit_pkg;

	localparam int DEPTH_DEF = 32;

	localparam int TYPE_W   = 3;
	localparam int ID_W     = 16;
	localparam int POS_W    = 48;
	localparam int LEN_W    = 47;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;
	localparam int END_W    = POS_W + 1;

	localparam logic [TYPE_W-1:0] REQ_INSERT   = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_REMOVE   = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_FIND     = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_SHIFT    = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_RANGE    = 3'd4;
	localparam logic [TYPE_W-1:0] REQ_DURATION = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_HIT    = 2'd3;

	typedef struct packed {
		logic signed [POS_W-1:0] start;
		logic [LEN_W-1:0]        length;
		logic [ID_W-1:0]         ident;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_WALK,
		S_ADJ_WALK,
		S_SORT_PRIME,
		S_SORT_LOAD,
		S_SORT_WALK,
		S_RM_WALK,
		S_FIND_WALK,
		S_RANGE_WALK,
		S_DUR_WALK,
		S_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_INS_INIT,
		OP_WALK,
		OP_SCAN_INIT,
		OP_ADJ_STEP,
		OP_SORT_PRIME,
		OP_SORT_LOAD,
		OP_RM_STEP,
		OP_FIND_STEP,
		OP_RANGE_STEP,
		OP_DUR_STEP,
		OP_RESP
	} dp_op_t;

	typedef struct packed {
		logic [TYPE_W-1:0] rtype;
		logic empty;
		logic full;
		logic delta_zero;
		logic range_ok;
		logic walk_done;
		logic scan_last;
		logic match;
		logic sort_more;
		logic cnt_ge2;
		logic can_emit;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/sit_ram.sv */
// Generic simple dual-port RAM with registered read that holds when not read.
`default_nettype none
module sit_ram #(
	parameter int W  = 8,
	parameter int N  = 4,
	parameter int AW = (N > 1) ? $clog2(N) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [N];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/sit_dp.sv */
// Datapath: request latch, table memory, walk counters, compare units, result register.
`default_nettype none
module sit_dp
	import sit_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dp_op_t                   op,
	output dp_stat_t                      stat,
	input  wire logic [TYPE_W-1:0]        req_type,
	input  wire logic [ID_W-1:0]          clip_id,
	input  wire logic signed [POS_W-1:0]  start_pos,
	input  wire logic [LEN_W-1:0]         clip_length,
	input  wire logic signed [POS_W-1:0]  shift_delta,
	input  wire logic signed [POS_W-1:0]  range_end,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [STATUS_W-1:0]           status,
	output logic [ID_W-1:0]               out_id,
	output logic signed [POS_W-1:0]       out_start,
	output logic [LEN_W-1:0]              out_length,
	output logic [SLOT_W-1:0]             slot_index,
	output logic [POS_W-1:0]              total_span,
	output logic                          last
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// latched request
	logic [TYPE_W-1:0]       type_q;
	logic [ID_W-1:0]         id_q;
	logic signed [POS_W-1:0] pos_q;
	logic [LEN_W-1:0]        len_q;
	logic signed [POS_W-1:0] delta_q;
	logic signed [POS_W-1:0] rend_q;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] j_q, k_q, i_q, pend_q;
	entry_t        key_q;
	logic          found_q, pend_v_q;
	logic signed [END_W-1:0] best_q;
	logic signed [POS_W-1:0] fstart_q;
	logic [LEN_W-1:0]        flen_q;

	// memory port
	logic               we, re;
	logic [AW-1:0]      waddr, raddr;
	entry_t             wdata;
	logic [ENTRY_W-1:0] rdata;
	entry_t             rd;

	sit_ram #(.W(ENTRY_W), .N(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd = entry_t'(rdata);

	// compare units on the entry just read
	logic                    rd_before, key_ahead, walk_done, rd_match, rd_ge_pos, hit;
	logic signed [END_W-1:0] rd_end, adj_sum;
	logic signed [POS_W-1:0] adj_start;
	logic                    can_emit;

	assign rd_before = (rd.start != key_q.start) ? (rd.start < key_q.start)
	                                             : (rd.ident < key_q.ident);
	assign key_ahead = (key_q.start != rd.start) ? (key_q.start < rd.start)
	                                             : (key_q.ident < rd.ident);
	// insert moves entries that do not sort ahead of the key; the re-sort after a
	// shift moves only entries the key sorts ahead of, so equal entries keep order
	assign walk_done = (j_q == '0) || ((type_q == REQ_SHIFT) ? !key_ahead : rd_before);
	assign rd_match  = (rd.ident == id_q);
	assign rd_ge_pos = (rd.start >= pos_q);
	assign rd_end    = {rd.start[POS_W-1], rd.start} + $signed({2'b00, rd.length});
	assign hit       = (rd.start < pos_q) ? (rd_end > $signed({pos_q[POS_W-1], pos_q}))
	                                      : (rd.start < rend_q);
	assign adj_sum   = {rd.start[POS_W-1], rd.start} + {delta_q[POS_W-1], delta_q};

	// saturate to the signed 48-bit range
	always_comb begin
		if (adj_sum[END_W-1] != adj_sum[END_W-2]) begin
			adj_start = adj_sum[END_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
			                             : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			adj_start = adj_sum[POS_W-1:0];
		end
	end

	assign can_emit = !out_valid || !out_stall;

	always_comb begin
		stat.rtype      = type_q;
		stat.empty      = (cnt_q == '0);
		stat.full       = (cnt_q == CW'(DEPTH));
		stat.delta_zero = (delta_q == '0);
		stat.range_ok   = (rend_q > pos_q);
		stat.walk_done  = walk_done;
		stat.scan_last  = ((CW'(k_q) + CW'(1)) == cnt_q);
		stat.match      = rd_match;
		stat.sort_more  = ((CW'(i_q) + CW'(1)) < cnt_q);
		stat.cnt_ge2    = (cnt_q >= CW'(2));
		stat.can_emit   = can_emit;
	end

	// memory commands and result word
	logic                    emit;
	logic [STATUS_W-1:0]     e_status;
	logic [ID_W-1:0]         e_id;
	logic signed [POS_W-1:0] e_start;
	logic [LEN_W-1:0]        e_len;
	logic [SLOT_W-1:0]       e_slot;
	logic [POS_W-1:0]        e_span;
	logic                    e_last;

	always_comb begin
		we       = 1'b0;
		waddr    = j_q;
		wdata    = key_q;
		re       = 1'b0;
		raddr    = '0;
		emit     = 1'b0;
		e_status = ST_OK;
		e_id     = '0;
		e_start  = '0;
		e_len    = '0;
		e_slot   = '0;
		e_span   = '0;
		e_last   = 1'b1;
		unique case (op) inside
			OP_INS_INIT: begin
				re    = 1'b1;
				raddr = AW'(cnt_q - CW'(1));
			end
			OP_WALK: begin
				we    = 1'b1;
				waddr = j_q;
				if (!walk_done) begin
					wdata = rd;
					re    = 1'b1;
					raddr = j_q - AW'(2);
				end
			end
			OP_SCAN_INIT: begin
				re    = 1'b1;
				raddr = '0;
			end
			OP_ADJ_STEP: begin
				we          = 1'b1;
				waddr       = k_q;
				wdata       = rd;
				if (rd_ge_pos) begin
					wdata.start = adj_start;
				end
				re          = 1'b1;
				raddr       = k_q + AW'(1);
			end
			OP_SORT_PRIME: begin
				re    = 1'b1;
				raddr = i_q;
			end
			OP_SORT_LOAD: begin
				re    = 1'b1;
				raddr = i_q - AW'(1);
			end
			OP_RM_STEP: begin
				we    = found_q;
				waddr = k_q - AW'(1);
				wdata = rd;
				re    = 1'b1;
				raddr = k_q + AW'(1);
			end
			OP_FIND_STEP, OP_DUR_STEP: begin
				re    = 1'b1;
				raddr = k_q + AW'(1);
			end
			OP_RANGE_STEP: begin
				re     = 1'b1;
				raddr  = k_q + AW'(1);
				emit   = hit && pend_v_q;
				e_slot = SLOT_W'(pend_q);
				e_last = 1'b0;
			end
			OP_RESP: begin
				emit = 1'b1;
				case (type_q)
					REQ_INSERT: begin
						e_status = stat.full ? ST_FULL : ST_OK;
						e_id     = id_q;
					end
					REQ_REMOVE: begin
						e_status = found_q ? ST_OK : ST_NOT_FOUND;
						e_id     = found_q ? id_q : '0;
					end
					REQ_FIND: begin
						e_status = found_q ? ST_OK : ST_NOT_FOUND;
						e_id     = found_q ? id_q : '0;
						e_start  = found_q ? fstart_q : '0;
						e_len    = found_q ? flen_q : '0;
					end
					REQ_RANGE: begin
						e_status = pend_v_q ? ST_OK : ST_NO_HIT;
						e_slot   = pend_v_q ? SLOT_W'(pend_q) : '0;
					end
					REQ_DURATION: begin
						e_span = best_q[POS_W-1:0];
					end
					default: begin
						e_status = ST_OK;
					end
				endcase
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			found_q   <= 1'b0;
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (op)
				OP_LATCH: begin
					found_q  <= 1'b0;
					pend_v_q <= 1'b0;
				end
				OP_RM_STEP: begin
					if (rd_match) begin
						found_q <= 1'b1;
					end
				end
				OP_FIND_STEP: begin
					if (rd_match) begin
						found_q <= 1'b1;
					end
				end
				OP_RANGE_STEP: begin
					if (hit) begin
						pend_v_q <= 1'b1;
					end
				end
				OP_RESP: begin
					if (type_q == REQ_INSERT && !stat.full) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (type_q == REQ_REMOVE && found_q) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// walk registers and payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status     <= e_status;
			out_id     <= e_id;
			out_start  <= e_start;
			out_length <= e_len;
			slot_index <= e_slot;
			total_span <= e_span;
			last       <= e_last;
		end
		unique case (op) inside
			OP_LATCH: begin
				type_q  <= req_type;
				id_q    <= clip_id;
				pos_q   <= start_pos;
				len_q   <= clip_length;
				delta_q <= shift_delta;
				rend_q  <= range_end;
				best_q  <= '0;
			end
			OP_INS_INIT: begin
				key_q.start  <= pos_q;
				key_q.length <= len_q;
				key_q.ident  <= id_q;
				j_q          <= AW'(cnt_q);
			end
			OP_WALK: begin
				if (walk_done) begin
					i_q <= i_q + AW'(1);
				end else begin
					j_q <= j_q - AW'(1);
				end
			end
			OP_SCAN_INIT: begin
				k_q <= '0;
			end
			OP_ADJ_STEP: begin
				k_q <= k_q + AW'(1);
				i_q <= AW'(1);
			end
			OP_SORT_LOAD: begin
				key_q <= rd;
				j_q   <= i_q;
			end
			OP_RM_STEP, OP_DUR_STEP: begin
				k_q <= k_q + AW'(1);
				if (op == OP_DUR_STEP && rd_end > best_q) begin
					best_q <= rd_end;
				end
			end
			OP_FIND_STEP: begin
				k_q      <= k_q + AW'(1);
				fstart_q <= rd.start;
				flen_q   <= rd.length;
			end
			OP_RANGE_STEP: begin
				k_q <= k_q + AW'(1);
				if (hit) begin
					pend_q <= k_q;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_valid) |-> !out_stall)
		else $error("result overwritten while stalled");
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CW'(waddr) < CW'(DEPTH)))
		else $error("table write beyond depth");
	a_find_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FIND_STEP && rd_match) |=> found_q)
		else $error("find match lost");
`endif
endmodule
`default_nettype wire

/* hw/rtl/sit_ctrl.sv */
// Controller: request sequencer state machine for the sorted interval table.
`default_nettype none
module sit_ctrl
	import sit_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dp_stat_t stat,
	output dp_op_t        op
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (stat.rtype)
					REQ_INSERT: state_d = stat.full ? S_RESP : S_INS_WALK;
					REQ_REMOVE: state_d = stat.empty ? S_RESP : S_RM_WALK;
					REQ_FIND: state_d = stat.empty ? S_RESP : S_FIND_WALK;
					REQ_SHIFT: state_d = (stat.empty || stat.delta_zero) ? S_RESP : S_ADJ_WALK;
					REQ_RANGE: state_d = (stat.empty || !stat.range_ok) ? S_RESP : S_RANGE_WALK;
					REQ_DURATION: state_d = stat.empty ? S_RESP : S_DUR_WALK;
					default: state_d = S_IDLE;
				endcase
			end
			S_INS_WALK: begin
				if (stat.walk_done) state_d = S_RESP;
			end
			S_ADJ_WALK: begin
				if (stat.scan_last) state_d = stat.cnt_ge2 ? S_SORT_PRIME : S_RESP;
			end
			S_SORT_PRIME: state_d = S_SORT_LOAD;
			S_SORT_LOAD:  state_d = S_SORT_WALK;
			S_SORT_WALK: begin
				if (stat.walk_done) state_d = stat.sort_more ? S_SORT_PRIME : S_RESP;
			end
			S_RM_WALK, S_DUR_WALK: begin
				if (stat.scan_last) state_d = S_RESP;
			end
			S_FIND_WALK: begin
				if (stat.match || stat.scan_last) state_d = S_RESP;
			end
			S_RANGE_WALK: begin
				if (stat.can_emit && stat.scan_last) state_d = S_RESP;
			end
			S_RESP: begin
				if (stat.can_emit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		op       = OP_NONE;
		in_stall = (state_q != S_IDLE);
		unique case (state_q) inside
			S_IDLE:       op = in_valid ? OP_LATCH : OP_NONE;
			S_DISPATCH: begin
				case (stat.rtype) inside
					REQ_INSERT: op = stat.full ? OP_NONE : OP_INS_INIT;
					REQ_REMOVE, REQ_FIND, REQ_DURATION:
						op = stat.empty ? OP_NONE : OP_SCAN_INIT;
					REQ_SHIFT:
						op = (stat.empty || stat.delta_zero) ? OP_NONE : OP_SCAN_INIT;
					REQ_RANGE:
						op = (stat.empty || !stat.range_ok) ? OP_NONE : OP_SCAN_INIT;
					default: op = OP_NONE;
				endcase
			end
			S_INS_WALK, S_SORT_WALK: op = OP_WALK;
			S_ADJ_WALK:   op = OP_ADJ_STEP;
			S_SORT_PRIME: op = OP_SORT_PRIME;
			S_SORT_LOAD:  op = OP_SORT_LOAD;
			S_RM_WALK:    op = OP_RM_STEP;
			S_FIND_WALK:  op = OP_FIND_STEP;
			S_DUR_WALK:   op = OP_DUR_STEP;
			S_RANGE_WALK: op = stat.can_emit ? OP_RANGE_STEP : OP_NONE;
			S_RESP:       op = stat.can_emit ? OP_RESP : OP_NONE;
			default:      op = OP_NONE;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISPATCH))
		else $error("accepted word not dispatched");
	a_resp_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && !stat.can_emit) |=> (state_q == S_RESP))
		else $error("response left without emitting");
	a_range_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_RANGE_STEP) |-> stat.can_emit)
		else $error("range step while result stalled");
`endif
endmodule
`default_nettype wire

/* hw/rtl/sorted_interval_table.sv */
// Sorted interval table: top level joining the controller and the datapath.
//
// Keeps up to DEPTH intervals (id, signed start, length) in one table memory,
// sorted by start and then by id. One request word is taken at a time; in_stall
// is high from acceptance until the request's final result is loaded into the
// output register, which then holds it for the consumer while the next request
// word may already be taken. A request that walks the memory does so one entry
// per cycle (a range query only while the output is not stalled) through the
// single registered read port and single write port:
//   insert        walk down from the top, moving entries
//   remove, find  scan from slot 0 (find stops at the first match)
//   duration      scan from slot 0
//   range query   scan from slot 0; one word per hit, each hit held until the
//                 next one is found, so the last can carry last = 1
//   shift         an adjust pass from slot 0, then, with two or more entries,
//                 an insertion sort over the table
// Request types six and seven are dropped with no result.
// The table contents are not cleared at reset; only the count is.
`default_nettype none
module sorted_interval_table
	import sit_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [TYPE_W-1:0]       req_type,
	input  wire logic [ID_W-1:0]         clip_id,
	input  wire logic signed [POS_W-1:0] start_pos,
	input  wire logic [LEN_W-1:0]        clip_length,
	input  wire logic signed [POS_W-1:0] shift_delta,
	input  wire logic signed [POS_W-1:0] range_end,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [STATUS_W-1:0]          status,
	output logic [ID_W-1:0]              out_id,
	output logic signed [POS_W-1:0]      out_start,
	output logic [LEN_W-1:0]             out_length,
	output logic [SLOT_W-1:0]            slot_index,
	output logic [POS_W-1:0]             total_span,
	output logic                         last
);
	dp_stat_t stat;
	dp_op_t   op;

	sit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.op       (op)
	);

	sit_dp #(.DEPTH(DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.stat        (stat),
		.req_type    (req_type),
		.clip_id     (clip_id),
		.start_pos   (start_pos),
		.clip_length (clip_length),
		.shift_delta (shift_delta),
		.range_end   (range_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_id      (out_id),
		.out_start   (out_start),
		.out_length  (out_length),
		.slot_index  (slot_index),
		.total_span  (total_span),
		.last        (last)
	);
endmodule
`default_nettype wire
